// ===== sv/epoch_seconds_to_calendar_unit_macros.svh =====
// Assertion helpers shared by the calendar converter RTL.
// Every macro samples on clk_i and is held off while rst_ni is low.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// Condition must hold at every edge.
`define ECAL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define ECAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ECAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ecal_pkg.sv =====
package ecal_pkg;

  // Time of day plus whole days since the epoch, front to back
  typedef struct packed {
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ecal_clock_t;

  // Finished broken-down time
  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month_number;
    logic [8:0] day_of_year;
    logic [7:0] year_since_1900;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ecal_date_t;

  // Reciprocal multipliers: q = (x * MUL) >> SHIFT, exact over the used range
  localparam logic [31:0] DIV60_MUL    = 32'h8888_8889;
  localparam int          DIV60_SHIFT  = 37;
  localparam logic [18:0] DIV3_MUL     = 19'd349526;   // x/24 = (x>>3)/3
  localparam int          DIV3_SHIFT   = 20;
  localparam logic [16:0] DIV365_MUL   = 17'd91930;
  localparam int          DIV365_SHIFT = 25;
  localparam logic [17:0] DIV7_MUL     = 18'd149797;
  localparam int          DIV7_SHIFT   = 20;

  localparam logic [7:0]  YEAR_OFFSET  = 8'd70;     // 1970 - 1900
  localparam logic [7:0]  SKIP_LEAP_N  = 8'd130;    // 2100, not a leap year
  localparam logic [2:0]  EPOCH_WDAY   = 3'd4;      // 1970-01-01 was a Thursday
  localparam int          MONTHS       = 12;
  localparam logic [3:0]  MARCH_IDX    = 4'd2;

  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Days from 1970-01-01 to Jan 1 of year 1970+n.
  // Leap years in range sit at n = 2 mod 4, minus 2100.
  function automatic logic [15:0] year_start(input logic [7:0] n);
    logic [15:0] base;
    logic [15:0] leaps;
    base  = 16'(n) * 16'd365;
    leaps = 16'((9'(n) + 9'd1) >> 2);
    if (n > SKIP_LEAP_N) begin
      leaps = leaps - 16'd1;
    end
    return base + leaps;
  endfunction

  function automatic logic is_leap(input logic [7:0] n);
    return (n[1:0] == 2'd2) && (n != SKIP_LEAP_N);
  endfunction

endpackage

// ===== sv/ecal_front.sv =====
module ecal_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         in_stamp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ecal_pkg::ecal_clock_t out_clock_o
);
  import ecal_pkg::*;

  logic s0_en, s1_en, s2_en, s3_en;
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q;

  logic [31:0] s0_stamp_q;
  logic [63:0] s0_prod_q;
  logic [26:0] s1_mins_q;
  logic [5:0]  s1_sec_q;
  logic [58:0] s1_prod_q;
  logic [20:0] s2_hrs_q;
  logic [5:0]  s2_min_q;
  logic [5:0]  s2_sec_q;
  logic [36:0] s2_prod_q;
  ecal_clock_t s3_clock_q;

  logic [26:0] mins;
  logic [31:0] sec_full;
  logic [58:0] prod1;
  logic [20:0] hrs;
  logic [26:0] min_full;
  logic [36:0] prod2;
  logic [15:0] days;
  logic [20:0] hour_full;

  // Stall chain: a stage loads when it is empty or its successor moves
  assign s3_en = !s3_v_q || out_ready_i;
  assign s2_en = !s2_v_q || s3_en;
  assign s1_en = !s1_v_q || s2_en;
  assign s0_en = !s0_v_q || s1_en;
  assign in_ready_o = s0_en;

  // Seconds -> minutes -> hours -> days
  always_comb begin
    mins     = s0_prod_q[63:DIV60_SHIFT];
    sec_full = s0_stamp_q - (32'(mins) * 32'd60);
    prod1    = 59'(mins) * 59'(DIV60_MUL);
    hrs      = s1_prod_q[57:DIV60_SHIFT];
    min_full = s1_mins_q - (27'(hrs) * 27'd60);
    prod2    = 37'(hrs[20:3]) * 37'(DIV3_MUL);
    days     = s2_prod_q[35:DIV3_SHIFT];
    hour_full = s2_hrs_q - (21'(days) * 21'd24);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s0_en) s0_v_q <= in_valid_i;
      if (s1_en) s1_v_q <= s0_v_q;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (s0_en && in_valid_i) begin
      s0_stamp_q <= in_stamp_i;
      s0_prod_q  <= 64'(in_stamp_i) * 64'(DIV60_MUL);
    end
    if (s1_en && s0_v_q) begin
      s1_mins_q <= mins;
      s1_sec_q  <= sec_full[5:0];
      s1_prod_q <= prod1;
    end
    if (s2_en && s1_v_q) begin
      s2_hrs_q  <= hrs;
      s2_min_q  <= min_full[5:0];
      s2_sec_q  <= s1_sec_q;
      s2_prod_q <= prod2;
    end
    if (s3_en && s2_v_q) begin
      s3_clock_q.days   <= days;
      s3_clock_q.hour   <= hour_full[4:0];
      s3_clock_q.minute <= s2_min_q;
      s3_clock_q.second <= s2_sec_q;
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_clock_o = s3_clock_q;

endmodule

// ===== sv/ecal_fifo.sv =====
`include "epoch_seconds_to_calendar_unit_macros.svh"

module ecal_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ecal_pkg::ecal_clock_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ecal_pkg::ecal_clock_t out_data_o
);
  import ecal_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ecal_clock_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != FULL_CNT);
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  `ECAL_ASSERT_ALWAYS(a_count_bound, count_q <= FULL_CNT, "queue fill above depth")
  `ECAL_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CNT_W'(1), "lost push")
  `ECAL_ASSERT_NEXT(a_count_dn, pop && !push, count_q == $past(count_q) - CNT_W'(1), "lost pop")

endmodule

// ===== sv/ecal_back.sv =====
`include "epoch_seconds_to_calendar_unit_macros.svh"

module ecal_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ecal_pkg::ecal_clock_t in_clock_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ecal_pkg::ecal_date_t  out_date_o
);
  import ecal_pkg::*;

  logic b0_en, b1_en, b2_en;
  logic b0_v_q, b1_v_q, b2_v_q;

  ecal_clock_t b0_clock_q;
  logic [32:0] b0_yprod_q;
  logic [34:0] b0_wprod_q;
  ecal_clock_t b1_clock_q;
  logic [7:0]  b1_n_q;
  logic [8:0]  b1_yday_q;
  logic [2:0]  b1_wday_q;
  ecal_date_t  b2_date_q;

  logic [16:0] wday_num;
  logic [7:0]  n0;
  logic [14:0] wq;
  logic [16:0] wday_full;
  logic [15:0] start0, start1, start_sel;
  logic        step_back;
  logic [7:0]  n_sel;
  logic [15:0] yday_full;
  logic        leap;
  logic [3:0]  mon_idx;
  logic [8:0]  mon_start;
  logic [8:0]  mday_full;

  assign b2_en = !b2_v_q || out_ready_i;
  assign b1_en = !b1_v_q || b2_en;
  assign b0_en = !b0_v_q || b1_en;
  assign in_ready_o = b0_en;

  assign wday_num = 17'(in_clock_i.days) + 17'(EPOCH_WDAY);

  // Year estimate, one-step correction, weekday remainder
  always_comb begin
    n0        = b0_yprod_q[32:DIV365_SHIFT];
    wq        = b0_wprod_q[34:DIV7_SHIFT];
    wday_full = 17'(b0_clock_q.days) + 17'(EPOCH_WDAY) - (17'(wq) * 17'd7);
    start0    = year_start(n0);
    start1    = year_start(n0 - 8'd1);
    step_back = (start0 > b0_clock_q.days);
    n_sel     = step_back ? (n0 - 8'd1) : n0;
    start_sel = step_back ? start1 : start0;
    yday_full = b0_clock_q.days - start_sel;
  end

  // Month search over the start table; leap day counts from March on
  always_comb begin
    leap    = is_leap(b1_n_q);
    mon_idx = '0;
    for (int m = 1; m < MONTHS; m++) begin
      if (b1_yday_q >= MONTH_START[m] + ((leap && (m >= 2)) ? 9'd1 : 9'd0)) begin
        mon_idx = 4'(m);
      end
    end
    mon_start = MONTH_START[mon_idx] + ((leap && (mon_idx >= MARCH_IDX)) ? 9'd1 : 9'd0);
    mday_full = b1_yday_q - mon_start + 9'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      if (b0_en) b0_v_q <= in_valid_i;
      if (b1_en) b1_v_q <= b0_v_q;
      if (b2_en) b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b0_en && in_valid_i) begin
      b0_clock_q <= in_clock_i;
      b0_yprod_q <= 33'(in_clock_i.days) * 33'(DIV365_MUL);
      b0_wprod_q <= 35'(wday_num) * 35'(DIV7_MUL);
    end
    if (b1_en && b0_v_q) begin
      b1_clock_q <= b0_clock_q;
      b1_n_q     <= n_sel;
      b1_yday_q  <= yday_full[8:0];
      b1_wday_q  <= wday_full[2:0];
    end
    if (b2_en && b1_v_q) begin
      b2_date_q.second          <= b1_clock_q.second;
      b2_date_q.minute          <= b1_clock_q.minute;
      b2_date_q.hour            <= b1_clock_q.hour;
      b2_date_q.weekday         <= b1_wday_q;
      b2_date_q.year_since_1900 <= b1_n_q + YEAR_OFFSET;
      b2_date_q.day_of_year     <= b1_yday_q;
      b2_date_q.month_number    <= mon_idx + 4'd1;
      b2_date_q.day_of_month    <= mday_full[4:0];
    end
  end

  assign out_valid_o = b2_v_q;
  assign out_date_o  = b2_date_q;

  `ECAL_ASSERT_IMPL(a_month_range, out_valid_o, (out_date_o.month_number != 4'd0) && (out_date_o.month_number <= 4'd12) && (out_date_o.day_of_month != 5'd0), "month or day out of range")
  `ECAL_ASSERT_IMPL(a_feb_len, out_valid_o && (out_date_o.month_number == 4'd2), out_date_o.day_of_month <= 5'd29, "february too long")
  `ECAL_ASSERT_IMPL(a_yday_wday, out_valid_o, (out_date_o.day_of_year <= 9'd365) && (out_date_o.weekday <= 3'd6), "day of year or weekday out of range")

endmodule

// ===== sv/epoch_seconds_to_calendar_unit.sv =====
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// broken-down Gregorian time (second, minute, hour, weekday with Sunday as 0,
// year since 1900, zero-based day of year, month 1..12, day of month). One
// word is accepted every clock cycle unless back-pressure from the output
// reaches the input, and one result word comes back per input; each result
// word passes through eight register stages: a four-stage front (reciprocal
// multiplies splitting off seconds, minutes, hours and days), one queue entry,
// and a three-stage back (year estimate and correction, weekday, month table
// search). The queue depth is QUEUE_DEPTH words and lets the front keep
// accepting while the output stalls.
module epoch_seconds_to_calendar_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] stamp_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // second[5:0] minute[11:6] hour[16:12]
                                      // weekday[19:17] year_since_1900[27:20]
                                      // day_of_year[36:28] month_number[40:37]
                                      // day_of_month[45:41], zero[47:46]
);
  import ecal_pkg::*;

  logic        fr_valid, fr_ready;
  ecal_clock_t fr_clock;
  logic        q_valid, q_ready;
  ecal_clock_t q_clock;
  ecal_date_t  date;

  ecal_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_stamp_i  (s_axis_tdata),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_clock_o (fr_clock)
  );

  ecal_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_clock),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_clock)
  );

  ecal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_clock_i  (q_clock),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_date_o  (date)
  );

  // Output word packing, seconds lowest, zero pad on top
  assign m_axis_tdata = {2'b00, date.day_of_month, date.month_number, date.day_of_year,
                         date.year_since_1900, date.weekday, date.hour, date.minute,
                         date.second};

endmodule

// ===== verif/epoch_seconds_to_calendar_unit_tb.sv =====
module epoch_seconds_to_calendar_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecal_pkg::*;

  localparam int RANDOM_WORDS  = 1230;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES  = 20;
  localparam int DIRECTED_ROWS = 22;
  localparam int SECS_PER_DAY  = 86400;

  // Directed stimulus row: typed result only where it is obvious
  typedef struct {
    logic [31:0] stamp;
    bit          typed;
    ecal_date_t  want;
  } stim_row_t;

  // Expectation waiting for its result word
  typedef struct {
    logic [31:0] stamp;
    ecal_date_t  want;
  } date_check_t;

  // Typed fields: day_of_month, month, day_of_year, year, weekday, hour, minute, second
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'd0,          1'b1, '{5'd1, 4'd1, 9'd0,  8'd70,  3'd4, 5'd0,  6'd0,  6'd0}},
    '{32'd59,         1'b0, '0},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b1, '{5'd1, 4'd1, 9'd0,  8'd70,  3'd4, 5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b1, '{5'd2, 4'd1, 9'd1,  8'd70,  3'd5, 5'd0,  6'd0,  6'd0}},
    '{32'd31535999,   1'b0, '0},  // last second of 1970
    '{32'd31536000,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},  // leap day 1972
    '{32'd94694399,   1'b0, '0},  // day 365 of a leap year
    '{32'd94694400,   1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd946684800,  1'b0, '0},  // 2000, leap by the 400 rule
    '{32'd951782400,  1'b0, '0},
    '{32'd951868800,  1'b0, '0},
    '{32'd4107542399, 1'b0, '0},  // 2100-02-28, century year not leap
    '{32'd4107542400, 1'b0, '0},
    '{32'h7FFFFFFF,   1'b0, '0},
    '{32'h80000000,   1'b0, '0},
    '{32'h55555555,   1'b0, '0},
    '{32'hFFFFFFFF,   1'b1, '{5'd7, 4'd2, 9'd37, 8'd206, 3'd0, 5'd6,  6'd28, 6'd15}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  date_check_t pending_dates[$];
  int          error_count   = 0;
  int          words_sent    = 0;
  int          words_checked = 0;
  int          idle_cycles   = 0;
  bit          steady_phase  = 1'b0;
  int          min_year      = 255;
  int          max_year      = 0;
  int          leap_days_hit = 0;

  epoch_seconds_to_calendar_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Gregorian leap days in years 1..y
  function automatic int unsigned leap_days_thru(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Days from the epoch to Jan 1 of 1900 + ys
  function automatic int unsigned days_to_year(int unsigned ys);
    return 365 * (ys - 70) + leap_days_thru(ys + 1899) - leap_days_thru(1969);
  endfunction

  function automatic bit is_leap_year(int unsigned ys);
    int unsigned full;
    full = ys + 1900;
    return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
  endfunction

  // Broken-down calendar time of one timestamp
  function automatic ecal_date_t calendar_of(logic [31:0] stamp);
    int unsigned first_day [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned secs;
    int unsigned days;
    int unsigned ys;
    int unsigned yday;
    int unsigned mon;
    int unsigned adj;
    bit          leap;
    ecal_date_t  d;
    secs = stamp % SECS_PER_DAY;
    days = stamp / SECS_PER_DAY;
    ys   = days / 365 + 70;
    while (ys > 70 && days_to_year(ys) > days) ys--;
    yday = days - days_to_year(ys);
    leap = is_leap_year(ys);
    mon  = 12;
    while (mon > 1) begin
      adj = (leap && mon > 2) ? 1 : 0;
      if (yday >= first_day[mon-1] + adj) break;
      mon--;
    end
    adj = (leap && mon > 2) ? 1 : 0;
    d.second          = 6'(secs % 60);
    d.minute          = 6'((secs / 60) % 60);
    d.hour            = 5'(secs / 3600);
    d.weekday         = 3'((days + 4) % 7);
    d.year_since_1900 = 8'(ys);
    d.day_of_year     = 9'(yday);
    d.month_number    = 4'(mon);
    d.day_of_month    = 5'(yday - (first_day[mon-1] + adj) + 1);
    return d;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random timestamp, weighted toward year edges, the end of February and both ends of the range
  function automatic logic [31:0] random_stamp();
    int          r;
    int unsigned ys;
    longint      s;
    r = $urandom_range(0, 99);
    ys = $urandom_range(70, 206);
    if (r < 30) begin
      s = longint'($urandom());
    end else if (r < 60) begin
      s = longint'(days_to_year(ys)) * SECS_PER_DAY
          + longint'($urandom_range(0, 4 * SECS_PER_DAY)) - 2 * SECS_PER_DAY;
    end else if (r < 80) begin
      s = (longint'(days_to_year(ys)) + $urandom_range(57, 60)) * SECS_PER_DAY
          + $urandom_range(0, SECS_PER_DAY - 1);
    end else if (r < 90) begin
      s = $urandom_range(0, 200000);
    end else begin
      s = longint'(32'hFFFFFFFF) - $urandom_range(0, 100000000);
    end
    if (s < 0) s = 0;
    if (s > longint'(32'hFFFFFFFF)) s = longint'(32'hFFFFFFFF);
    return 32'(s);
  endfunction

  // Present one word and hold it until accepted
  task automatic send_stamp(logic [31:0] stamp, bit typed, ecal_date_t typed_want);
    int          gap;
    date_check_t entry;
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    do @(posedge clk_i); while (!s_axis_tready);
    entry.stamp = stamp;
    entry.want  = typed ? typed_want : calendar_of(stamp);
    pending_dates.push_back(entry);
    words_sent++;
  endtask

  task automatic wait_drained();
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] stamp, int unsigned want,
                             int unsigned got);
    if (want != got) begin
      $display("%0t: stamp %0d %s mismatch: expected %0d, got %0d",
               $time, stamp, name, want, got);
      error_count++;
    end
  endtask

  // Output stall pattern
  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady_phase && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    date_check_t entry;
    ecal_date_t  got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = ecal_date_t'(m_axis_tdata[45:0]);
      if (pending_dates.size() == 0) begin
        $display("%0t: result word with nothing pending: expected none, got %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        entry = pending_dates.pop_front();
        check_field("second",          entry.stamp, entry.want.second,          got.second);
        check_field("minute",          entry.stamp, entry.want.minute,          got.minute);
        check_field("hour",            entry.stamp, entry.want.hour,            got.hour);
        check_field("weekday",         entry.stamp, entry.want.weekday,         got.weekday);
        check_field("year_since_1900", entry.stamp, entry.want.year_since_1900,
                    got.year_since_1900);
        check_field("day_of_year",     entry.stamp, entry.want.day_of_year,     got.day_of_year);
        check_field("month_number",    entry.stamp, entry.want.month_number,    got.month_number);
        check_field("day_of_month",    entry.stamp, entry.want.day_of_month,    got.day_of_month);
        if (entry.want.year_since_1900 < min_year) min_year = entry.want.year_since_1900;
        if (entry.want.year_since_1900 > max_year) max_year = entry.want.year_since_1900;
        if (entry.want.month_number == 4'd2 && entry.want.day_of_month == 5'd29)
          leap_days_hit++;
        words_checked++;
      end
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results pending",
               $time, IDLE_LIMIT, pending_dates.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int run_left;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_stamp(directed_rows[i].stamp, directed_rows[i].typed, directed_rows[i].want);

    // Let the pipe empty before the random part
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    run_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (run_left == 0) begin
        steady_phase = ($urandom_range(0, 3) == 0);
        run_left     = $urandom_range(50, 150);
      end
      run_left--;
      if (n == RANDOM_WORDS / 2) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      send_stamp(random_stamp(), 1'b0, '0);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d timestamps (%0d directed), checked %0d results field by field",
             words_sent, DIRECTED_ROWS, words_checked);
    $display("Years %0d..%0d reached, %0d leap-day results seen",
             min_year + 1900, max_year + 1900, leap_days_hit);
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               pending_dates.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ecal_pkg.sv
sv/ecal_front.sv
sv/ecal_fifo.sv
sv/ecal_back.sv
sv/epoch_seconds_to_calendar_unit.sv
verif/epoch_seconds_to_calendar_unit_tb.sv
